/* rtl/ept_pkg.sv */
// Shared types and constants of the edit position tracker.
`timescale 1ns / 1ps

package ept_pkg;

  // Default field widths
  localparam int unsigned LINE_WIDTH = 20;
  localparam int unsigned COL_WIDTH  = 16;
  localparam int unsigned OP_WIDTH   = 3;

  // Edit event codes
  typedef enum logic [OP_WIDTH-1:0] {
    OP_SET      = 3'd0,
    OP_TEXT_INS = 3'd1,
    OP_TEXT_REM = 3'd2,
    OP_WRAP     = 3'd3,
    OP_UNWRAP   = 3'd4,
    OP_LINE_INS = 3'd5,
    OP_LINE_REM = 3'd6
  } op_t;

  // Per-event result flags
  typedef struct packed {
    logic moved;
    logic inserted_at;
    logic deleted_before;
    logic deleted_after;
    logic anchor_deleted;
  } flags_t;

endpackage

/* rtl/ept_ifs.sv */
// Request and result channel interfaces of the edit position tracker.
`timescale 1ns / 1ps

interface ept_in_if #(
  parameter int unsigned LINE_WIDTH = ept_pkg::LINE_WIDTH,
  parameter int unsigned COL_WIDTH  = ept_pkg::COL_WIDTH
);
  logic                        valid;
  logic                        ready;
  logic [ept_pkg::OP_WIDTH-1:0] opcode;
  logic [LINE_WIDTH-1:0]       edit_line;
  logic [COL_WIDTH-1:0]        edit_col;
  logic [COL_WIDTH-1:0]        edit_len;
  logic                        line_flag;
  logic [LINE_WIDTH-1:0]       last_line;

  modport source (output valid, opcode, edit_line, edit_col, edit_len, line_flag,
                  last_line, input ready);
  modport sink (input valid, opcode, edit_line, edit_col, edit_len, line_flag,
                last_line, output ready);
endinterface

interface ept_out_if #(
  parameter int unsigned LINE_WIDTH = ept_pkg::LINE_WIDTH,
  parameter int unsigned COL_WIDTH  = ept_pkg::COL_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [LINE_WIDTH-1:0] anchor_line;
  logic [COL_WIDTH-1:0]  anchor_col;
  logic                  moved;
  logic                  inserted_at;
  logic                  deleted_before;
  logic                  deleted_after;
  logic                  anchor_deleted;

  modport source (output valid, anchor_line, anchor_col, moved, inserted_at,
                  deleted_before, deleted_after, anchor_deleted, input ready);
  modport sink (input valid, anchor_line, anchor_col, moved, inserted_at,
                deleted_before, deleted_after, anchor_deleted, output ready);
endinterface

/* rtl/ept_update.sv */
// Next-anchor logic: applies one edit event to the current anchor.
`timescale 1ns / 1ps

module ept_update #(
  parameter int unsigned LINE_WIDTH = ept_pkg::LINE_WIDTH,
  parameter int unsigned COL_WIDTH  = ept_pkg::COL_WIDTH
) (
  input  logic [LINE_WIDTH-1:0]        cur_line,
  input  logic [COL_WIDTH-1:0]         cur_col,
  input  logic                         move_on_insert,
  input  logic [ept_pkg::OP_WIDTH-1:0] opcode,
  input  logic [LINE_WIDTH-1:0]        edit_line,
  input  logic [COL_WIDTH-1:0]         edit_col,
  input  logic [COL_WIDTH-1:0]         edit_len,
  input  logic                         line_flag,
  input  logic [LINE_WIDTH-1:0]        last_line,
  output logic [LINE_WIDTH-1:0]        nxt_line,
  output logic [COL_WIDTH-1:0]         nxt_col,
  output ept_pkg::flags_t              flags
);

  logic [COL_WIDTH:0]    col_plus_len;
  logic [COL_WIDTH:0]    col_plus_col;
  logic [COL_WIDTH:0]    rem_end;
  logic [COL_WIDTH-1:0]  col_plus_len_sat;
  logic [COL_WIDTH-1:0]  col_plus_col_sat;
  logic [LINE_WIDTH:0]   next_line;
  logic [LINE_WIDTH-1:0] line_up;
  logic [LINE_WIDTH-1:0] line_down;
  logic                  same_line;
  logic                  at_col;
  logic                  past_col;

  // Sums one bit wider, then saturate columns at all ones
  assign col_plus_len     = {1'b0, cur_col} + {1'b0, edit_len};
  assign col_plus_col     = {1'b0, cur_col} + {1'b0, edit_col};
  assign rem_end          = {1'b0, edit_col} + {1'b0, edit_len};
  assign col_plus_len_sat = col_plus_len[COL_WIDTH] ? '1 : col_plus_len[COL_WIDTH-1:0];
  assign col_plus_col_sat = col_plus_col[COL_WIDTH] ? '1 : col_plus_col[COL_WIDTH-1:0];

  // Line steps saturate at the top and at zero
  assign next_line = {1'b0, edit_line} + {{LINE_WIDTH{1'b0}}, 1'b1};
  assign line_up   = (&cur_line) ? cur_line : cur_line + {{(LINE_WIDTH-1){1'b0}}, 1'b1};
  assign line_down = (cur_line == '0) ? cur_line
                                      : cur_line - {{(LINE_WIDTH-1){1'b0}}, 1'b1};

  assign same_line = (cur_line == edit_line);
  assign at_col    = (cur_col == edit_col);
  assign past_col  = (cur_col > edit_col);

  // Apply the event
  always_comb begin
    nxt_line = cur_line;
    nxt_col  = cur_col;
    flags    = '0;
    case (ept_pkg::op_t'(opcode))
      ept_pkg::OP_SET: begin
        flags.moved = !same_line || !at_col;
        nxt_line    = edit_line;
        nxt_col     = edit_col;
      end
      ept_pkg::OP_TEXT_INS: begin
        if (same_line && (past_col || (move_on_insert && at_col))) begin
          flags.inserted_at = at_col;
          flags.moved       = 1'b1;
          nxt_col           = col_plus_len_sat;
        end
      end
      ept_pkg::OP_TEXT_REM: begin
        if (same_line && past_col) begin
          flags.moved = 1'b1;
          if ({1'b0, cur_col} > rem_end) begin
            nxt_col = cur_col - edit_len;
          end else begin
            flags.deleted_before = ({1'b0, cur_col} == rem_end);
            flags.anchor_deleted = ({1'b0, cur_col} != rem_end);
            nxt_col              = edit_col;
          end
        end else if (same_line && at_col) begin
          flags.deleted_after = 1'b1;
        end
      end
      ept_pkg::OP_WRAP: begin
        if (line_flag && (cur_line > edit_line)) begin
          nxt_line    = line_up;
          flags.moved = 1'b1;
        end else if (same_line && (past_col || (move_on_insert && at_col))) begin
          nxt_line    = line_up;
          nxt_col     = cur_col - edit_col;
          flags.moved = 1'b1;
        end
      end
      ept_pkg::OP_UNWRAP: begin
        if (line_flag && ({1'b0, cur_line} > next_line)) begin
          nxt_line    = line_down;
          flags.moved = 1'b1;
        end else if ({1'b0, cur_line} == next_line) begin
          flags.moved = 1'b1;
          if (line_flag || (cur_col < edit_len)) begin
            nxt_line = edit_line;
            nxt_col  = col_plus_col_sat;
          end else begin
            nxt_col = cur_col - edit_len;
          end
        end
      end
      ept_pkg::OP_LINE_INS: begin
        if (cur_line >= edit_line) begin
          nxt_line    = line_up;
          flags.moved = 1'b1;
        end
      end
      ept_pkg::OP_LINE_REM: begin
        if (cur_line > edit_line) begin
          nxt_line    = line_down;
          flags.moved = 1'b1;
        end else if (same_line) begin
          nxt_line = (edit_line <= last_line) ? edit_line
                     : edit_line - {{(LINE_WIDTH-1){1'b0}}, 1'b1};
          nxt_col              = '0;
          flags.anchor_deleted = 1'b1;
          flags.moved          = 1'b1;
        end
      end
      default: begin
        flags = '0;
      end
    endcase
  end

endmodule

/* rtl/edit_position_tracker_top.sv */
// Top level of the edit position tracker: request register, anchor state, result register.
//
// Usage:
//   in_chan carries one edit request (opcode, edit_line, edit_col, edit_len,
//   line_flag, last_line); a request is taken when valid and ready are high.
//   out_chan returns one result per request: the anchor after the edit and
//   the flags moved, inserted_at, deleted_before, deleted_after, anchor_deleted.
//   cfg_we/cfg_wdata write move_on_insert; write it only while no request is
//   in flight.
// Timing: the anchor update is a single compare-and-add step between the request
//   register, which captures a request, and the result register, which drives
//   out_chan. Throughput: one request per cycle while out_chan is not stalled.
// Reset (rst_n low, synchronous): anchor goes to line 0, column 0,
//   move_on_insert to 0, both stages empty.
// Stall: when out_chan.ready is low the result holds; one more request can
//   wait in the request register, after which in_chan.ready drops.
`timescale 1ns / 1ps

module edit_position_tracker_top #(
  parameter int unsigned LINE_WIDTH = ept_pkg::LINE_WIDTH,
  parameter int unsigned COL_WIDTH  = ept_pkg::COL_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  ept_in_if.sink    in_chan,
  ept_out_if.source out_chan,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic                         moi_r;
  logic [LINE_WIDTH-1:0]        cur_line_r;
  logic [COL_WIDTH-1:0]         cur_col_r;
  logic                         s1_valid_r;
  logic [ept_pkg::OP_WIDTH-1:0] s1_opcode_r;
  logic [LINE_WIDTH-1:0]        s1_line_r;
  logic [COL_WIDTH-1:0]         s1_col_r;
  logic [COL_WIDTH-1:0]         s1_len_r;
  logic                         s1_flag_r;
  logic [LINE_WIDTH-1:0]        s1_last_r;
  logic                         out_valid_r;
  logic [LINE_WIDTH-1:0]        out_line_r;
  logic [COL_WIDTH-1:0]         out_col_r;
  ept_pkg::flags_t              out_flags_r;
  logic [LINE_WIDTH-1:0]        line_nxt;
  logic [COL_WIDTH-1:0]         col_nxt;
  ept_pkg::flags_t              flags_nxt;
  logic                         out_free;
  logic                         s1_fire;
  logic                         in_ready;
  logic                         in_fire;

  // Handshake
  assign out_free = !out_valid_r || out_chan.ready;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_fire  = in_chan.valid && in_ready;

  assign in_chan.ready = in_ready;

  ept_update #(
    .LINE_WIDTH (LINE_WIDTH),
    .COL_WIDTH  (COL_WIDTH)
  ) u_update (
    .cur_line       (cur_line_r),
    .cur_col        (cur_col_r),
    .move_on_insert (moi_r),
    .opcode         (s1_opcode_r),
    .edit_line      (s1_line_r),
    .edit_col       (s1_col_r),
    .edit_len       (s1_len_r),
    .line_flag      (s1_flag_r),
    .last_line      (s1_last_r),
    .nxt_line       (line_nxt),
    .nxt_col        (col_nxt),
    .flags          (flags_nxt)
  );

  // Control state: config, anchor, stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moi_r       <= 1'b0;
      cur_line_r  <= '0;
      cur_col_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        moi_r <= cfg_wdata;
      end
      if (s1_fire) begin
        cur_line_r <= line_nxt;
        cur_col_r  <= col_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload: capture request, capture result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode_r <= in_chan.opcode;
      s1_line_r   <= in_chan.edit_line;
      s1_col_r    <= in_chan.edit_col;
      s1_len_r    <= in_chan.edit_len;
      s1_flag_r   <= in_chan.line_flag;
      s1_last_r   <= in_chan.last_line;
    end
    if (s1_fire) begin
      out_line_r  <= line_nxt;
      out_col_r   <= col_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  // Drive the result channel
  assign out_chan.valid          = out_valid_r;
  assign out_chan.anchor_line    = out_line_r;
  assign out_chan.anchor_col     = out_col_r;
  assign out_chan.moved          = out_flags_r.moved;
  assign out_chan.inserted_at    = out_flags_r.inserted_at;
  assign out_chan.deleted_before = out_flags_r.deleted_before;
  assign out_chan.deleted_after  = out_flags_r.deleted_after;
  assign out_chan.anchor_deleted = out_flags_r.anchor_deleted;

`ifndef SYNTH
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> ($stable(cur_line_r) && $stable(cur_col_r)))
    else $error("anchor changed without a request");

  a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (out_valid_r && (out_line_r == cur_line_r) && (out_col_r == cur_col_r)))
    else $error("result register disagrees with anchor");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_flags_r.inserted_at, out_flags_r.deleted_before,
                              out_flags_r.deleted_after, out_flags_r.anchor_deleted}))
    else $error("conflicting result flags");

  a_flags_imply_moved: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_flags_r.inserted_at || out_flags_r.deleted_before ||
                     out_flags_r.anchor_deleted)) |-> out_flags_r.moved)
    else $error("move flag missing");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("request refused with free stage");
`endif

endmodule
